// ===== rtl/core/cbs_pkg.sv =====
// Shared types and constants for the character LCD bus sequencer.
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

    // Request modes
    localparam logic [2:0] MODE_INIT       = 3'd0;
    localparam logic [2:0] MODE_COMMAND    = 3'd1;
    localparam logic [2:0] MODE_CHARACTER  = 3'd2;
    localparam logic [2:0] MODE_SET_CURSOR = 3'd3;
    localparam logic [2:0] MODE_SCROLL_L   = 3'd4;
    localparam logic [2:0] MODE_SCROLL_R   = 3'd5;

    // Register indexes on the APB port
    localparam logic [1:0] REG_BUS_8BIT  = 2'd0;
    localparam logic [1:0] REG_ROWS      = 2'd1;
    localparam logic [1:0] REG_CHAR_5X10 = 2'd2;

    // Controller command bytes
    localparam logic [7:0] CMD_FUNC     = 8'h20;
    localparam logic [7:0] FUNC_8BIT    = 8'h10;
    localparam logic [7:0] FUNC_2LINE   = 8'h08;
    localparam logic [7:0] FUNC_5X10    = 8'h04;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_SHIFT_L  = 8'h18;
    localparam logic [7:0] CMD_SHIFT_R  = 8'h1C;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [6:0] LINE_OFFSET_INIT = 7'h40;
    localparam logic [6:0] LINE_OFFSET_TOP  = 7'h67;
    localparam logic [6:0] LINE_OFFSET_WRAP = 7'h27;

    // Extra hold times in microseconds
    localparam int WAKE_LONG_US    = 4500;
    localparam int WAKE8_LONG_US   = 4400;
    localparam int WAKE_SHORT_US   = 150;
    localparam int CLEAR_EXTRA_US  = 2000;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] INIT4_LAST_STEP = 4'd11;
    localparam logic [STEP_W-1:0] INIT8_LAST_STEP = 4'd6;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic [5:0] column;
        logic [1:0] row;
    } cbs_in_t;

    typedef struct packed {
        logic        rs;
        logic [7:0]  bus_value;
        logic [15:0] wait_before_us;
        logic [12:0] wait_after_us;
        logic        last;
    } cbs_out_t;

    // Decoded request as held while its strobes go out
    typedef struct packed {
        logic       init;
        logic       bus8;
        logic       rs;
        logic [7:0] cmd_byte;
        logic [7:0] func;
    } cbs_plan_t;

endpackage

`default_nettype wire

// ===== rtl/core/cbs_req_decode.sv =====
// Request decode: turns one input item into a strobe plan and the next line offset.
`timescale 1ns / 1ps
`default_nettype none

module cbs_req_decode
    import cbs_pkg::*;
(
    input  wire cbs_in_t    item,
    input  wire logic       bus_8bit,
    input  wire logic [2:0] rows,
    input  wire logic       char_5x10,
    input  wire logic [6:0] line_offset,
    output cbs_plan_t       plan,
    output logic            plan_valid,
    output logic [6:0]      line_offset_next
);

    logic [7:0] func;
    logic [2:0] max_row;
    logic [1:0] row_clamped;

    always_comb
    begin
        func = CMD_FUNC;
        if (bus_8bit)
            func = func | FUNC_8BIT;
        if (rows != 3'd1)
            func = func | FUNC_2LINE;
        if (char_5x10 && (rows == 3'd1))
            func = func | FUNC_5X10;

        max_row = (rows == 3'd0) ? 3'd0 : rows - 3'd1;
        row_clamped = ({1'b0, item.row} > max_row) ? max_row[1:0] : item.row;
    end

    always_comb
    begin
        plan.init        = 1'b0;
        plan.bus8        = bus_8bit;
        plan.rs          = 1'b0;
        plan.cmd_byte    = item.data_byte;
        plan.func        = func;
        plan_valid       = item.mode inside {[MODE_INIT:MODE_SCROLL_R]};
        line_offset_next = line_offset;
        case (item.mode)
            MODE_INIT:
            begin
                plan.init        = 1'b1;
                line_offset_next = LINE_OFFSET_INIT;
            end
            MODE_COMMAND:
            begin
                plan.cmd_byte = item.data_byte;
            end
            MODE_CHARACTER:
            begin
                if (item.data_byte == CHAR_NEWLINE)
                    plan.cmd_byte = {1'b1, line_offset};
                else
                begin
                    plan.rs       = 1'b1;
                    plan.cmd_byte = item.data_byte;
                end
            end
            MODE_SET_CURSOR:
            begin
                // 0x80 | (column + 0x40*row), low eight bits
                plan.cmd_byte = {1'b1, row_clamped[0], item.column};
            end
            MODE_SCROLL_L:
            begin
                line_offset_next = (line_offset == LINE_OFFSET_TOP) ?
                                   LINE_OFFSET_INIT : line_offset + 7'd1;
                plan.cmd_byte    = CMD_SHIFT_L;
            end
            MODE_SCROLL_R:
            begin
                line_offset_next = (line_offset == 7'd0) ?
                                   LINE_OFFSET_WRAP : line_offset - 7'd1;
                plan.cmd_byte    = CMD_SHIFT_R;
            end
            default:
            begin
                plan_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbs_strobe_gen.sv =====
// Strobe generator: fields of one bus strobe from the held plan and the step count.
`timescale 1ns / 1ps
`default_nettype none

module cbs_strobe_gen
    import cbs_pkg::*;
#(
    parameter int SETTLE_US   = 60,
    parameter int POWER_UP_US = 50000
)
(
    input  wire cbs_plan_t          plan,
    input  wire logic [STEP_W-1:0]  step,
    output cbs_out_t                strobe
);

    localparam int PW_SAT = (POWER_UP_US > 65535) ? 65535 : POWER_UP_US;
    localparam logic [15:0] PW_US       = 16'(PW_SAT);
    localparam logic [12:0] WA_SETTLE   = 13'(SETTLE_US);
    localparam logic [12:0] WA_LONG     = 13'(SETTLE_US + WAKE_LONG_US);
    localparam logic [12:0] WA_LONG8    = 13'(SETTLE_US + WAKE8_LONG_US);
    localparam logic [12:0] WA_SHORT    = 13'(SETTLE_US + WAKE_SHORT_US);
    localparam logic [12:0] WA_CLEAR    = 13'(SETTLE_US + CLEAR_EXTRA_US);

    logic [STEP_W-1:0] tail_step;
    logic [7:0]        tail_byte;

    always_comb
    begin
        // 4-bit init: byte index of the common tail, two nibbles per byte
        tail_step = step - 4'd4;
        case (tail_step[2:1])
            2'd0:    tail_byte = plan.func;
            2'd1:    tail_byte = CMD_DISP_ON;
            2'd2:    tail_byte = CMD_CLEAR;
            default: tail_byte = CMD_ENTRY;
        endcase

        strobe.rs             = 1'b0;
        strobe.bus_value      = 8'd0;
        strobe.wait_before_us = 16'd0;
        strobe.wait_after_us  = WA_SETTLE;
        strobe.last           = 1'b0;

        if (!plan.init)
        begin
            strobe.rs = plan.rs;
            if (plan.bus8)
            begin
                strobe.bus_value = plan.cmd_byte;
                strobe.last      = 1'b1;
            end
            else if (step == 4'd0)
                strobe.bus_value = {4'd0, plan.cmd_byte[7:4]};
            else
            begin
                strobe.bus_value = {4'd0, plan.cmd_byte[3:0]};
                strobe.last      = 1'b1;
            end
        end
        else if (plan.bus8)
        begin
            strobe.last = (step == INIT8_LAST_STEP);
            case (step)
                4'd0:
                begin
                    strobe.bus_value      = plan.func;
                    strobe.wait_before_us = PW_US;
                    strobe.wait_after_us  = WA_LONG8;
                end
                4'd1:
                begin
                    strobe.bus_value     = plan.func;
                    strobe.wait_after_us = WA_SHORT;
                end
                4'd2, 4'd3: strobe.bus_value = plan.func;
                4'd4:       strobe.bus_value = CMD_DISP_ON;
                4'd5:
                begin
                    strobe.bus_value     = CMD_CLEAR;
                    strobe.wait_after_us = WA_CLEAR;
                end
                default:    strobe.bus_value = CMD_ENTRY;
            endcase
        end
        else
        begin
            strobe.last = (step == INIT4_LAST_STEP);
            case (step)
                4'd0:
                begin
                    strobe.bus_value      = 8'h03;
                    strobe.wait_before_us = PW_US;
                    strobe.wait_after_us  = WA_LONG;
                end
                4'd1:
                begin
                    strobe.bus_value     = 8'h03;
                    strobe.wait_after_us = WA_LONG;
                end
                4'd2:
                begin
                    strobe.bus_value     = 8'h03;
                    strobe.wait_after_us = WA_SHORT;
                end
                4'd3:    strobe.bus_value = 8'h02;
                default:
                begin
                    if (!tail_step[0])
                        strobe.bus_value = {4'd0, tail_byte[7:4]};
                    else
                    begin
                        strobe.bus_value = {4'd0, tail_byte[3:0]};
                        if (tail_byte == CMD_CLEAR)
                            strobe.wait_after_us = WA_CLEAR;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_bus_sequencer_unit.sv =====
// Top level of the character LCD bus sequencer: registers, handshakes and APB port.
//
// Usage:
//   in_valid/in_ready/in_item carry requests (init, command, character, set
//   cursor, scroll left, scroll right). Each request expands into one or more
//   bus strobes on out_valid/out_ready/out_item, one strobe per item, with
//   last marking the final strobe of a request. Modes 6 and 7 are taken and
//   produce nothing.
//   After a request is accepted it is held as the active plan, and its first
//   strobe is then loaded into the output register. One strobe leaves per
//   cycle while the receiver keeps up. A request has 1 or 2 strobes as a
//   byte request, 7 (8-bit) or 12 (4-bit) as init. The next request is taken
//   in the cycle its predecessor's final strobe is issued.
//   A stalled receiver holds the output register; the sequencer then holds
//   its step and in_ready drops once a request is waiting behind it.
//   Reset clears all valids, loads the reset configuration (4-bit bus, two
//   rows, 5x8 font) and sets the line offset to 0x40. Configuration must be
//   written over APB while no request is in flight; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_bus_sequencer_unit
    import cbs_pkg::*;
#(
    parameter int SETTLE_US   = 60,
    parameter int POWER_UP_US = 50000
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire cbs_in_t     in_item,

    output logic             out_valid,
    input  wire logic        out_ready,
    output cbs_out_t         out_item,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic              bus_8bit_reg;
    logic [2:0]        rows_reg;
    logic              char_5x10_reg;
    logic [6:0]        line_offset_reg;
    logic [6:0]        line_offset_next;

    logic              act_valid_reg;
    cbs_plan_t         act_reg;
    logic [STEP_W-1:0] step_reg;

    logic              out_valid_reg;
    cbs_out_t          out_reg;

    cbs_plan_t         plan;
    logic              plan_valid;
    cbs_out_t          strobe;
    logic              emit;
    logic              in_fire;
    logic              cfg_write;
    logic [1:0]        reg_index;

    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (reg_index)
            REG_BUS_8BIT:  prdata = {31'd0, bus_8bit_reg};
            REG_ROWS:      prdata = {29'd0, rows_reg};
            REG_CHAR_5X10: prdata = {31'd0, char_5x10_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_8bit_reg  <= 1'b0;
            rows_reg      <= 3'd2;
            char_5x10_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_BUS_8BIT:  bus_8bit_reg  <= pwdata[0];
                REG_ROWS:      rows_reg      <= pwdata[2:0];
                REG_CHAR_5X10: char_5x10_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    cbs_req_decode u_decode (
        .item             (in_item),
        .bus_8bit         (bus_8bit_reg),
        .rows             (rows_reg),
        .char_5x10        (char_5x10_reg),
        .line_offset      (line_offset_reg),
        .plan             (plan),
        .plan_valid       (plan_valid),
        .line_offset_next (line_offset_next)
    );

    cbs_strobe_gen #(
        .SETTLE_US   (SETTLE_US),
        .POWER_UP_US (POWER_UP_US)
    ) u_strobe (
        .plan   (act_reg),
        .step   (step_reg),
        .strobe (strobe)
    );

    assign emit     = act_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !act_valid_reg || (emit && strobe.last);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_offset_reg <= LINE_OFFSET_INIT;
            act_valid_reg   <= 1'b0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
                line_offset_reg <= line_offset_next;

            if (in_fire)
            begin
                act_valid_reg <= plan_valid;
                step_reg      <= '0;
            end
            else if (emit)
            begin
                if (strobe.last)
                    act_valid_reg <= 1'b0;
                step_reg <= step_reg + 4'd1;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            act_reg <= plan;
        if (emit)
            out_reg <= strobe;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // A byte request on the 8-bit bus is a single strobe
    a_byte8_single: assert property (@(posedge clk) disable iff (!rst_n)
        (act_valid_reg && !act_reg.init && act_reg.bus8) |-> (step_reg == '0))
        else $error("8-bit byte request past its first strobe");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid_reg |-> (step_reg <= INIT4_LAST_STEP))
        else $error("strobe step beyond longest sequence");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && strobe.last && !in_fire) |=> !act_valid_reg)
        else $error("request still active after its final strobe");

    a_power_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !(act_reg.init && (step_reg == '0))) |-> (strobe.wait_before_us == 16'd0))
        else $error("power-up wait outside the first init strobe");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (act_valid_reg && out_valid_reg && !out_ready) |=> $stable(step_reg))
        else $error("step advanced while output stalled");

endmodule

`default_nettype wire
